// ===== rtl/tefc_pkg.sv =====
package tefc_pkg;

    typedef enum logic [2:0] {
        FMT_F32  = 3'd0,
        FMT_F16  = 3'd1,
        FMT_BF16 = 3'd2,
        FMT_F64  = 3'd3
    } fmt_t;

    localparam logic [31:0] F32_INF  = 32'h7f80_0000;
    localparam logic [31:0] F32_QNAN = 32'h7fc0_0000;

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic       sign;
        logic [4:0] exp;
        logic [9:0] man;
        logic [9:0] norm;
        logic [3:0] lz;
        logic [7:0] e32;
        logic [31:0] res;
        sign = h[15];
        exp  = h[14:10];
        man  = h[9:0];
        lz   = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (man[i])
                lz = 4'(9 - i);
        end
        norm = man << (lz + 4'd1);
        if (exp == 5'd0)
        begin
            if (man == 10'd0)
                res = {sign, 31'd0};
            else
            begin
                e32 = 8'd113 - 8'(lz) - 8'd1;
                res = {sign, e32, norm, 13'd0};
            end
        end
        else if (exp == 5'h1f)
            res = {sign, 8'hff, man, 13'd0};
        else
        begin
            e32 = 8'(exp) + 8'd112;
            res = {sign, e32, man, 13'd0};
        end
        return res;
    endfunction

    function automatic logic [31:0] double_to_single(input logic [63:0] d);
        logic        sign;
        logic [10:0] exp;
        logic [51:0] man;
        logic [63:0] sig;
        logic signed [12:0] fe;
        logic [5:0]  shift;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] mask;
        logic [31:0] mag;
        logic [31:0] res;
        sign  = d[63];
        exp   = d[62:52];
        man   = d[51:0];
        sig   = {11'd0, 1'b1, man};
        fe    = $signed({2'b00, exp}) - 13'sd896;
        shift = 6'd29;
        if (fe < 13'sd1)
            shift = 6'd29 + 6'(13'sd1 - fe);
        q     = sig >> shift;
        mask  = (64'd1 << shift) - 64'd1;
        rem   = sig & mask;
        half  = 64'd1 << (shift - 6'd1);
        if (rem > half || (rem == half && q[0]))
            q = q + 64'd1;
        if (fe >= 13'sd1)
            mag = {1'b0, 8'(fe - 13'sd1), 23'd0} + q[31:0];
        else
            mag = q[31:0];
        if (mag >= F32_INF)
            mag = F32_INF;
        if (exp == 11'h7ff)
        begin
            if (man == 52'd0)
                res = {sign, F32_INF[30:0]};
            else
                res = {sign, F32_QNAN[30:0]} | {10'd0, man[50:29]};
        end
        else if (exp == 11'd0)
            res = {sign, 31'd0};
        else if (fe >= 13'sd255)
            res = {sign, F32_INF[30:0]};
        else if (fe < 13'sd1 && (13'sd1 - fe) > 13'sd30)
            res = {sign, 31'd0};
        else
            res = {sign, mag[30:0]};
        return res;
    endfunction

endpackage

// ===== rtl/tensor_element_to_fp32_converter_top.sv =====
// Channel  | Valid     | Stall     | Payload
// input    | in_valid  | in_stall  | raw_word, end_of_tensor
// output   | out_valid | out_stall | single_bits, format_error, last_out
// config   | cfg_we    | -         | cfg_data (source_format)
// One transfer per cycle each way unless stalled, via the input register, then
// the result register. in_stall is high only when both stages are full and the
// output is stalled. rst_n clears valid flags and source_format to F32.
module tensor_element_to_fp32_converter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] raw_word,
    input  logic        end_of_tensor,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] single_bits,
    output logic        format_error,
    output logic        last_out
);
    import tefc_pkg::*;

    logic [2:0]  fmt_reg;
    logic        s1_valid_reg;
    logic [63:0] s1_word_reg;
    logic        s1_last_reg;
    logic        s2_valid_reg;
    logic [31:0] s2_bits_reg;
    logic        s2_err_reg;
    logic        s2_last_reg;
    logic [31:0] bits_next;
    logic        err_next;
    logic        s2_load;
    logic        s1_load;

    assign s2_load  = s1_valid_reg && (!s2_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s2_load;
    assign s1_load  = in_valid && !in_stall;

    always_comb
    begin
        bits_next = 32'd0;
        err_next  = 1'b0;
        case (fmt_reg)
            FMT_F32:  bits_next = s1_word_reg[31:0];
            FMT_F16:  bits_next = half_to_single(s1_word_reg[15:0]);
            FMT_BF16: bits_next = {s1_word_reg[15:0], 16'd0};
            FMT_F64:  bits_next = double_to_single(s1_word_reg);
            default:  err_next  = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg      <= FMT_F32;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                fmt_reg <= cfg_data;
            if (s1_load)
                s1_valid_reg <= 1'b1;
            else if (s2_load)
                s1_valid_reg <= 1'b0;
            if (s2_load)
                s2_valid_reg <= 1'b1;
            else if (!out_stall)
                s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_word_reg <= raw_word;
            s1_last_reg <= end_of_tensor;
        end
        if (s2_load)
        begin
            s2_bits_reg <= bits_next;
            s2_err_reg  <= err_next;
            s2_last_reg <= s1_last_reg;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign single_bits  = s2_bits_reg;
    assign format_error = s2_err_reg;
    assign last_out     = s2_last_reg;

endmodule
